/* hdl/hscf_pkg.sv */
// Shared types, codes and defaults for the sonar height complementary filter.
// No dependencies; every other file refers to this package by scoped names.
package hscf_pkg;

  // Default design parameters
  localparam int HISTORY_DEPTH   = 3;
  localparam int STARTUP_SAMPLES = 500;
  localparam int SAVE_PERIOD     = 4;
  localparam int DATA_WIDTH      = 32;

  // Fixed port field widths
  localparam int FIELD_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ACC      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_VEL      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 8'd3;

  // Register reset values, Q0.24
  localparam logic [GAIN_W-1:0] RST_GAIN_ACC      = 24'd6711;
  localparam logic [GAIN_W-1:0] RST_GAIN_VEL      = 24'd671089;
  localparam logic [GAIN_W-1:0] RST_GAIN_POS      = 24'd838861;
  localparam logic [GAIN_W-1:0] RST_SAMPLE_PERIOD = 24'd83886;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_acc;
    logic [GAIN_W-1:0] gain_vel;
    logic [GAIN_W-1:0] gain_pos;
    logic [GAIN_W-1:0] sample_period;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL_ACC,
    ST_UPD_ACC,
    ST_MUL_VEL,
    ST_UPD_VEL,
    ST_MUL_POS,
    ST_UPD_POS,
    ST_CORR_ACC,
    ST_SUM_ACC,
    ST_MUL_DLT,
    ST_UPD_DLT,
    ST_HALF_SPD,
    ST_MUL_HGT,
    ST_UPD_HGT,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_STARTUP,
    OP_ERROR,
    OP_MULT,
    OP_UPD_ACC,
    OP_UPD_VEL,
    OP_UPD_POS,
    OP_CORR_ACC,
    OP_SUM_ACC,
    OP_UPD_DLT,
    OP_HALF_SPD,
    OP_UPD_HGT,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    GSEL_ACC,
    GSEL_VEL,
    GSEL_POS,
    GSEL_PERIOD
  } gain_sel_t;

  typedef struct packed {
    dp_op_t    op;
    gain_sel_t gsel;
  } cmd_t;

  typedef struct packed {
    logic startup_done;
    logic out_busy;
  } status_t;

endpackage

/* hdl/hscf_if.sv */
// Valid/ready channel interfaces: sample input, fused result output, register writes.
// Depends on hscf_pkg for field widths.
interface hscf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hscf_pkg::FIELD_W-1:0] height_sample;
  logic signed [hscf_pkg::FIELD_W-1:0] vert_accel;
  modport source(output valid, height_sample, vert_accel, input ready);
  modport sink(input valid, height_sample, vert_accel, output ready);
endinterface

interface hscf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hscf_pkg::FIELD_W-1:0] fused_height;
  logic signed [hscf_pkg::FIELD_W-1:0] fused_speed;
  logic signed [hscf_pkg::FIELD_W-1:0] fused_accel;
  modport source(output valid, fused_height, fused_speed, fused_accel, input ready);
  modport sink(input valid, fused_height, fused_speed, fused_accel, output ready);
endinterface

interface hscf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hscf_pkg::CFG_IDX_W-1:0]      index;
  logic [hscf_pkg::CFG_DATA_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hdl/sonar_height_complementary_filter_core.sv */
// Top level of the sonar height complementary filter.
// Depends on hscf_pkg, hscf_if, hscf_cfg_regs, hscf_ctrl and hscf_datapath.
//
// Use:
//   sample : valid/ready input, one height sample and one vertical
//            acceleration per transfer, both Q16.16 signed.
//   result : valid/ready output, fused height, speed and acceleration.
//   cfg    : register writes (index 0..3: gain_acc, gain_vel, gain_pos,
//            sample_period, Q0.24); always ready, unknown indexes dropped.
//            Write only while the filter is idle.
// The first STARTUP_SAMPLES transfers only latch the height offset, clear
// the corrections and give no result. Every later transfer runs one
// filter step: the sequencer steps one shared multiplier through five
// products and the adds between them, and the result register loads in
// the finish state. The next sample is taken once the sequencer is back
// in idle. One sample is in work at a time; a waiting result does not
// block the acceptance of the next.
// Reset (synchronous, active high) restores register defaults and clears
// all filter state. A stalled receiver holds the result; a finished step
// waits in its last state until the output register is free.
module sonar_height_complementary_filter_core #(
  parameter int DATA_WIDTH      = hscf_pkg::DATA_WIDTH,
  parameter int HISTORY_DEPTH   = hscf_pkg::HISTORY_DEPTH,
  parameter int STARTUP_SAMPLES = hscf_pkg::STARTUP_SAMPLES,
  parameter int SAVE_PERIOD     = hscf_pkg::SAVE_PERIOD
) (
  input  logic        clk,
  input  logic        rst,
  hscf_in_if.sink     sample,
  hscf_out_if.source  result,
  hscf_cfg_if.sink    cfg
);

  hscf_pkg::cfg_t    regs;
  hscf_pkg::cmd_t    cmd;
  hscf_pkg::status_t status;

  // register file for gains and time step
  hscf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // sequencer: one command per cycle to the datapath
  hscf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, filter state and output register
  hscf_datapath #(
    .DATA_WIDTH      (DATA_WIDTH),
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .STARTUP_SAMPLES (STARTUP_SAMPLES),
    .SAVE_PERIOD     (SAVE_PERIOD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .regs          (regs),
    .height_sample (sample.height_sample),
    .vert_accel    (sample.vert_accel),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .fused_height  (result.fused_height),
    .fused_speed   (result.fused_speed),
    .fused_accel   (result.fused_accel),
    .status        (status)
  );

endmodule

/* hdl/hscf_cfg_regs.sv */
// Configuration register file: gains and integration period, Q0.24.
// Depends on hscf_pkg and hscf_cfg_if.
module hscf_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  hscf_cfg_if.sink          cfg,
  output hscf_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_acc      <= hscf_pkg::RST_GAIN_ACC;
      regs.gain_vel      <= hscf_pkg::RST_GAIN_VEL;
      regs.gain_pos      <= hscf_pkg::RST_GAIN_POS;
      regs.sample_period <= hscf_pkg::RST_SAMPLE_PERIOD;
    end else if (cfg.valid) begin
      // keep the low 24 bits, drop writes to unknown indexes
      unique case (cfg.index)
        hscf_pkg::REG_GAIN_ACC:      regs.gain_acc      <= cfg.data[hscf_pkg::GAIN_W-1:0];
        hscf_pkg::REG_GAIN_VEL:      regs.gain_vel      <= cfg.data[hscf_pkg::GAIN_W-1:0];
        hscf_pkg::REG_GAIN_POS:      regs.gain_pos      <= cfg.data[hscf_pkg::GAIN_W-1:0];
        hscf_pkg::REG_SAMPLE_PERIOD: regs.sample_period <= cfg.data[hscf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/hscf_ctrl.sv */
// Sequencer for one filter step: issues datapath commands, one per state.
// Depends on hscf_pkg.
module hscf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hscf_pkg::status_t   status,
  output hscf_pkg::cmd_t      cmd
);

  hscf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hscf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hscf_pkg::ST_IDLE:     if (in_valid) state_next = hscf_pkg::ST_ERR;
      hscf_pkg::ST_ERR: begin
        if (status.startup_done) state_next = hscf_pkg::ST_MUL_ACC;
        else                     state_next = hscf_pkg::ST_IDLE;
      end
      hscf_pkg::ST_MUL_ACC:  state_next = hscf_pkg::ST_UPD_ACC;
      hscf_pkg::ST_UPD_ACC:  state_next = hscf_pkg::ST_MUL_VEL;
      hscf_pkg::ST_MUL_VEL:  state_next = hscf_pkg::ST_UPD_VEL;
      hscf_pkg::ST_UPD_VEL:  state_next = hscf_pkg::ST_MUL_POS;
      hscf_pkg::ST_MUL_POS:  state_next = hscf_pkg::ST_UPD_POS;
      hscf_pkg::ST_UPD_POS:  state_next = hscf_pkg::ST_CORR_ACC;
      hscf_pkg::ST_CORR_ACC: state_next = hscf_pkg::ST_SUM_ACC;
      hscf_pkg::ST_SUM_ACC:  state_next = hscf_pkg::ST_MUL_DLT;
      hscf_pkg::ST_MUL_DLT:  state_next = hscf_pkg::ST_UPD_DLT;
      hscf_pkg::ST_UPD_DLT:  state_next = hscf_pkg::ST_HALF_SPD;
      hscf_pkg::ST_HALF_SPD: state_next = hscf_pkg::ST_MUL_HGT;
      hscf_pkg::ST_MUL_HGT:  state_next = hscf_pkg::ST_UPD_HGT;
      hscf_pkg::ST_UPD_HGT:  state_next = hscf_pkg::ST_FINISH;
      hscf_pkg::ST_FINISH:   if (!status.out_busy) state_next = hscf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = hscf_pkg::OP_NONE;
    cmd.gsel = hscf_pkg::GSEL_ACC;
    unique case (state)
      hscf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = hscf_pkg::OP_CAPTURE;
      end
      hscf_pkg::ST_ERR: begin
        if (status.startup_done) cmd.op = hscf_pkg::OP_ERROR;
        else                     cmd.op = hscf_pkg::OP_STARTUP;
      end
      hscf_pkg::ST_MUL_ACC: begin
        cmd.op   = hscf_pkg::OP_MULT;
        cmd.gsel = hscf_pkg::GSEL_ACC;
      end
      hscf_pkg::ST_UPD_ACC:  cmd.op = hscf_pkg::OP_UPD_ACC;
      hscf_pkg::ST_MUL_VEL: begin
        cmd.op   = hscf_pkg::OP_MULT;
        cmd.gsel = hscf_pkg::GSEL_VEL;
      end
      hscf_pkg::ST_UPD_VEL:  cmd.op = hscf_pkg::OP_UPD_VEL;
      hscf_pkg::ST_MUL_POS: begin
        cmd.op   = hscf_pkg::OP_MULT;
        cmd.gsel = hscf_pkg::GSEL_POS;
      end
      hscf_pkg::ST_UPD_POS:  cmd.op = hscf_pkg::OP_UPD_POS;
      hscf_pkg::ST_CORR_ACC: cmd.op = hscf_pkg::OP_CORR_ACC;
      hscf_pkg::ST_SUM_ACC:  cmd.op = hscf_pkg::OP_SUM_ACC;
      hscf_pkg::ST_MUL_DLT: begin
        cmd.op   = hscf_pkg::OP_MULT;
        cmd.gsel = hscf_pkg::GSEL_PERIOD;
      end
      hscf_pkg::ST_UPD_DLT:  cmd.op = hscf_pkg::OP_UPD_DLT;
      hscf_pkg::ST_HALF_SPD: cmd.op = hscf_pkg::OP_HALF_SPD;
      hscf_pkg::ST_MUL_HGT: begin
        cmd.op   = hscf_pkg::OP_MULT;
        cmd.gsel = hscf_pkg::GSEL_PERIOD;
      end
      hscf_pkg::ST_UPD_HGT:  cmd.op = hscf_pkg::OP_UPD_HGT;
      hscf_pkg::ST_FINISH:   if (!status.out_busy) cmd.op = hscf_pkg::OP_FINISH;
    endcase
  end

  // an accepted sample always goes to the start-up or error step next
  a_accept_to_err: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == hscf_pkg::ST_ERR))
    else $error("accepted sample did not advance to the error step");

  // a finished step with a free output slot returns to idle
  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == hscf_pkg::ST_FINISH && !status.out_busy) |=> (state == hscf_pkg::ST_IDLE))
    else $error("finish step did not release the sequencer");

endmodule

/* hdl/hscf_datapath.sv */
// Filter datapath: state registers, shared multiplier, history line, output register.
// Depends on hscf_pkg; driven by commands from hscf_ctrl.
module hscf_datapath #(
  parameter int DATA_WIDTH      = hscf_pkg::DATA_WIDTH,
  parameter int HISTORY_DEPTH   = hscf_pkg::HISTORY_DEPTH,
  parameter int STARTUP_SAMPLES = hscf_pkg::STARTUP_SAMPLES,
  parameter int SAVE_PERIOD     = hscf_pkg::SAVE_PERIOD
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hscf_pkg::cmd_t                      cmd,
  input  hscf_pkg::cfg_t                      regs,
  input  logic signed [hscf_pkg::FIELD_W-1:0] height_sample,
  input  logic signed [hscf_pkg::FIELD_W-1:0] vert_accel,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [hscf_pkg::FIELD_W-1:0] fused_height,
  output logic signed [hscf_pkg::FIELD_W-1:0] fused_speed,
  output logic signed [hscf_pkg::FIELD_W-1:0] fused_accel,
  output hscf_pkg::status_t                   status
);

  localparam int DW   = DATA_WIDTH;
  localparam int FW   = hscf_pkg::FIELD_W;
  localparam int GW   = hscf_pkg::GAIN_W;
  localparam int WX   = (DW + 2 > FW + 2) ? DW + 2 : FW + 2;
  localparam int PW   = DW + GW + 2;
  localparam int CNTW = (STARTUP_SAMPLES < 1) ? 1 : $clog2(STARTUP_SAMPLES + 1);

  localparam logic signed [WX-1:0] SMAX = {{(WX-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WX-1:0] SMIN = {{(WX-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [WX-1:0] W_ONE = 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (GW - 1);

  typedef logic signed [DW-1:0] dval_t;
  typedef logic signed [WX-1:0] wide_t;

  function automatic dval_t sat(input wide_t v);
    if (v > SMAX)      return SMAX[DW-1:0];
    else if (v < SMIN) return SMIN[DW-1:0];
    else               return v[DW-1:0];
  endfunction

  function automatic wide_t ext(input dval_t v);
    return {{(WX-DW){v[DW-1]}}, v};
  endfunction

  function automatic dval_t in_sat(input logic signed [FW-1:0] x);
    wide_t w;
    w = {{(WX-FW){x[FW-1]}}, x};
    return sat(w);
  endfunction

  function automatic logic [FW-1:0] out_bits(input dval_t v);
    wide_t w;
    w = ext(v);
    return w[FW-1:0];
  endfunction

  // filter state
  logic [CNTW-1:0] startup_count;
  logic [1:0]      save_count;
  dval_t height_offset, accel_correction, speed_correction, height_correction;
  dval_t raw_height, raw_speed, previous_accel, corrected_speed;
  dval_t height_history [HISTORY_DEPTH];

  // working registers
  dval_t h_in, a_in, acc, dlt;
  logic signed [DW:0]   opnd;
  logic signed [PW-1:0] prod;

  logic signed [GW:0]   gain_sig;
  logic signed [PW-1:0] rnd_sum, rnd_shift;
  wide_t rnd, rnd_half, d_half, e_wide;
  dval_t err_part, err, fh_new, cs_new, acc_new, dlt_new, spd_half, hgt_inc;
  logic [1:0] save_inc;
  logic       push;

  always_comb begin
    unique case (cmd.gsel)
      hscf_pkg::GSEL_ACC:    gain_sig = $signed({1'b0, regs.gain_acc});
      hscf_pkg::GSEL_VEL:    gain_sig = $signed({1'b0, regs.gain_vel});
      hscf_pkg::GSEL_POS:    gain_sig = $signed({1'b0, regs.gain_pos});
      hscf_pkg::GSEL_PERIOD: gain_sig = $signed({1'b0, regs.sample_period});
    endcase
  end

  always_comb begin
    // product rounded half up to the Q16.16 grid
    rnd_sum   = prod + RND_HALF;
    rnd_shift = rnd_sum >>> GW;
    rnd       = rnd_shift[WX-1:0];
    rnd_half  = (rnd + W_ONE) >>> 1;
    d_half    = (ext(dlt) + W_ONE) >>> 1;
    err_part  = sat(ext(h_in) - ext(height_offset));
    err       = sat(ext(err_part) - ext(height_history[HISTORY_DEPTH-1]));
    e_wide    = ext(err);
    acc_new   = sat(ext(a_in) + ext(accel_correction));
    dlt_new   = sat(rnd_half);
    spd_half  = sat(ext(corrected_speed) + d_half);
    hgt_inc   = sat(rnd);
    fh_new    = sat(ext(raw_height) + ext(height_correction));
    cs_new    = sat(ext(raw_speed) + ext(speed_correction));
    save_inc  = save_count + 2'd1;
    push      = ({1'b0, save_inc} >= 3'(SAVE_PERIOD)) || (save_inc == 2'd0);
  end

  // shared multiplier, one product per multiply command
  always_ff @(posedge clk) begin
    if (cmd.op == hscf_pkg::OP_MULT) prod <= opnd * gain_sig;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      hscf_pkg::OP_CAPTURE: begin
        h_in <= in_sat(height_sample);
        a_in <= in_sat(vert_accel);
      end
      hscf_pkg::OP_ERROR:    opnd <= e_wide[DW:0];
      hscf_pkg::OP_CORR_ACC: acc  <= acc_new;
      hscf_pkg::OP_SUM_ACC: begin
        opnd <= {acc[DW-1], acc} + {previous_accel[DW-1], previous_accel};
      end
      hscf_pkg::OP_UPD_DLT:  dlt  <= dlt_new;
      hscf_pkg::OP_HALF_SPD: opnd <= {spd_half[DW-1], spd_half};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_count     <= '0;
      save_count        <= '0;
      height_offset     <= '0;
      accel_correction  <= '0;
      speed_correction  <= '0;
      height_correction <= '0;
      raw_height        <= '0;
      raw_speed         <= '0;
      previous_accel    <= '0;
      corrected_speed   <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) height_history[i] <= '0;
    end else begin
      unique case (cmd.op)
        hscf_pkg::OP_STARTUP: begin
          accel_correction  <= '0;
          speed_correction  <= '0;
          height_correction <= '0;
          height_offset     <= h_in;
          startup_count     <= startup_count + CNTW'(1);
        end
        hscf_pkg::OP_UPD_ACC: accel_correction  <= sat(ext(accel_correction) + rnd);
        hscf_pkg::OP_UPD_VEL: speed_correction  <= sat(ext(speed_correction) + rnd);
        hscf_pkg::OP_UPD_POS: height_correction <= sat(ext(height_correction) + rnd);
        hscf_pkg::OP_UPD_HGT: begin
          raw_height <= sat(ext(raw_height) + ext(hgt_inc));
          raw_speed  <= sat(ext(raw_speed) + ext(dlt));
        end
        hscf_pkg::OP_FINISH: begin
          corrected_speed <= cs_new;
          previous_accel  <= acc;
          if (push) begin
            save_count <= '0;
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) height_history[i] <= height_history[i-1];
            height_history[0] <= fh_new;
          end else begin
            save_count <= save_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == hscf_pkg::OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == hscf_pkg::OP_FINISH) begin
      fused_height <= out_bits(fh_new);
      fused_speed  <= out_bits(cs_new);
      fused_accel  <= out_bits(acc);
    end
  end

  assign status.startup_done = (startup_count >= CNTW'(STARTUP_SAMPLES));
  assign status.out_busy     = out_valid && !out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> (cmd.op != hscf_pkg::OP_FINISH))
    else $error("result overwritten while the receiver stalls");

  a_startup_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hscf_pkg::OP_STARTUP) |-> !status.startup_done)
    else $error("start-up step issued after start-up ended");

  a_save_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == hscf_pkg::OP_FINISH) |=> ({1'b0, save_count} < 3'(SAVE_PERIOD)))
    else $error("save counter passed its period");

endmodule
